// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frame-buffer writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define GFW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checked property that also holds during reset.
`define GFW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GFW_ASSERT(lbl, clk, rstn, prop, msg)
`define GFW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/gfw_pkg.sv =====
// Shared types, constants and the 5x7 font table of the frame-buffer writer.
`default_nettype none

package gfw_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_CHAR  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam int STORE_DEPTH = 1024;
  localparam int STORE_AW    = 10;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd126;
  localparam int GLYPH_COUNT = 95;
  localparam logic [2:0] LAST_COL = 3'd4;
  localparam logic [2:0] LAST_ROW = 3'd6;

  // Location of one pixel in the frame store.
  typedef struct packed {
    logic                hit;
    logic [STORE_AW-1:0] idx;
    logic [7:0]          mask;
  } pix_loc_t;

  // One entry per printable code, columns left to right, most significant byte first.
  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700,
    40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001C224100,
    40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4030403F, 40'h6314081463,
    40'h0304780403, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204,
    40'h4040404040, 40'h0003050000, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h081454543C,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04780478,
    40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000,
    40'h0041360800, 40'h1008081008
  };

endpackage

`default_nettype wire

// ===== rtl/gfw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gfw_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gfw_pix_unit.sv =====
// Shared pixel address unit: bounds check, byte index and bit mask of one pixel.
`default_nettype none

module gfw_pix_unit
  import gfw_pkg::*;
#(
  parameter int DISP_WIDTH  = 128,
  parameter int DISP_HEIGHT = 64
) (
  input  wire logic [7:0] px,
  input  wire logic [7:0] py,
  output pix_loc_t        loc
);

  localparam logic [8:0]  WIDTH_C  = 9'(DISP_WIDTH);
  localparam logic [8:0]  HEIGHT_C = 9'(DISP_HEIGHT);
  localparam logic [13:0] DEPTH_C  = 14'(STORE_DEPTH);

  logic [13:0] full_idx;
  logic        on_screen;

  // Byte index is page times display width plus column.
  assign full_idx  = 14'(py[7:3]) * 14'(WIDTH_C) + 14'(px);
  assign on_screen = ({1'b0, px} < WIDTH_C) && ({1'b0, py} < HEIGHT_C);

  assign loc.hit  = on_screen && (full_idx < DEPTH_C);
  assign loc.idx  = full_idx[STORE_AW-1:0];
  assign loc.mask = 8'(8'd1 << py[2:0]);

endmodule

`default_nettype wire

// ===== rtl/glyph_framebuffer_writer.sv =====
// Top level of the glyph frame-buffer writer: command sequencer and frame store.
//
//   Channel  Direction  Ports                                           Handshake
//   in_      input      cmd, x_pos, y_pos, pixel_on, char_code,         in_valid / in_ready
//                       read_index
//   out_     output     read_data                                       out_valid / out_ready
//
// Each command runs from its acceptance through ST_DONE, which hands the result to the
// output register. A clear sweeps the whole store; a pixel, and each of the 35 pixels of
// a character, goes through address calculation, frame store read and write; a read
// fetches one byte; an unprintable character goes straight to ST_DONE. Every pixel is a
// read-modify-write of one byte. After reset a clearing pass writes zero to all 1024
// bytes, one per cycle, and in_ready stays low until that pass is done.
// A new transaction is taken as soon as the sequencer is idle, even while the
// previous result still waits in the output register for out_ready.
`default_nettype none
`include "assert_macros.svh"

module glyph_framebuffer_writer
  import gfw_pkg::*;
#(
  parameter int DISP_WIDTH  = 128,
  parameter int DISP_HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_x_pos,
  input  wire logic [7:0]  in_y_pos,
  input  wire logic        in_pixel_on,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [9:0]  in_read_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_data
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_RD,
    ST_WR,
    ST_RD_DATA,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [STORE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                clr_cmd_r, clr_cmd_nxt;
  logic [7:0]          x0_r, x0_nxt;
  logic [7:0]          y0_r, y0_nxt;
  logic [39:0]         glyph_r, glyph_nxt;
  logic [2:0]          col_r, col_nxt;
  logic [2:0]          row_r, row_nxt;
  logic                single_r, single_nxt;
  pix_loc_t            pix_r, pix_nxt;
  logic [7:0]          result_r, result_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_data_r, out_data_nxt;

  logic                in_accept;
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [STORE_AW-1:0] ram_raddr;
  logic [7:0]          ram_rdata;
  pix_loc_t            loc;
  logic [7:0]          px;
  logic [7:0]          py;
  logic [7:0]          col_byte;
  logic                pix_bit;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_accept     = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  // Pixel coordinates wrap at 256 before the bounds check.
  assign px       = x0_r + {5'b0, col_r};
  assign py       = y0_r + {5'b0, row_r};
  // The current glyph column always sits in the top byte; it shifts left per column.
  assign col_byte = glyph_r[39:32];
  assign pix_bit  = col_byte[row_r];

  gfw_pix_unit #(
    .DISP_WIDTH (DISP_WIDTH),
    .DISP_HEIGHT(DISP_HEIGHT)
  ) u_pix_unit (
    .px (px),
    .py (py),
    .loc(loc)
  );

  gfw_ram #(
    .DATA_W(8),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_cmd_nxt   = clr_cmd_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    glyph_nxt     = glyph_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    single_nxt    = single_r;
    pix_nxt       = pix_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = pix_r.idx;
    ram_wdata     = pix_bit ? (ram_rdata | pix_r.mask) : (ram_rdata & ~pix_r.mask);
    ram_re        = 1'b0;
    ram_raddr     = pix_r.idx;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        // Sweep the whole store, one byte per cycle.
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = 8'd0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == STORE_AW'(STORE_DEPTH - 1)) begin
          state_nxt = clr_cmd_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          result_nxt = 8'd0;
          x0_nxt     = in_x_pos;
          y0_nxt     = in_y_pos;
          col_nxt    = 3'd0;
          row_nxt    = 3'd0;
          single_nxt = 1'b0;
          case (in_cmd)
            CMD_CLEAR: begin
              clr_cnt_nxt = '0;
              clr_cmd_nxt = 1'b1;
              state_nxt   = ST_CLEAR;
            end
            CMD_PIXEL: begin
              // A single pixel runs as a one-pixel glyph with its bit in row 0.
              single_nxt = 1'b1;
              glyph_nxt  = {7'd0, in_pixel_on, 32'd0};
              state_nxt  = ST_CALC;
            end
            CMD_CHAR: begin
              if ((in_char_code >= FIRST_CODE) && (in_char_code <= LAST_CODE)) begin
                glyph_nxt = GLYPH_ROM[7'(in_char_code - FIRST_CODE)];
                state_nxt = ST_CALC;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            CMD_READ: begin
              ram_re    = 1'b1;
              ram_raddr = in_read_index;
              state_nxt = ST_RD_DATA;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_CALC: begin
        pix_nxt   = loc;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        ram_re    = pix_r.hit;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        // Off-screen pixels skip the write but still advance the walk.
        ram_we = pix_r.hit;
        if (single_r || ((col_r == LAST_COL) && (row_r == LAST_ROW))) begin
          state_nxt = ST_DONE;
        end else if (row_r == LAST_ROW) begin
          row_nxt   = 3'd0;
          col_nxt   = col_r + 3'd1;
          glyph_nxt = {glyph_r[31:0], 8'd0};
          state_nxt = ST_CALC;
        end else begin
          row_nxt   = row_r + 3'd1;
          state_nxt = ST_CALC;
        end
      end
      ST_RD_DATA: begin
        result_nxt = ram_rdata;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_cmd_r   <= 1'b0;
      col_r       <= 3'd0;
      row_r       <= 3'd0;
      single_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      single_r    <= single_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    glyph_r    <= glyph_nxt;
    pix_r      <= pix_nxt;
    result_r   <= result_nxt;
    out_data_r <= out_data_nxt;
  end

  `GFW_ASSERT(a_we_state, clk, rst_n, ram_we |-> (state_r == ST_CLEAR || state_r == ST_WR), "frame store written outside clear or pixel write")
  `GFW_ASSERT(a_clear_zero, clk, rst_n, (state_r == ST_CLEAR) |-> (ram_we && ram_wdata == 8'd0), "clearing pass must write zero")
  `GFW_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_DONE), "result raised without a finished transaction")
  `GFW_ASSERT(a_one_at_a_time, clk, rst_n, in_accept |=> !in_ready, "second transaction taken while the first is in work")
  `GFW_ASSERT(a_walk_range, clk, rst_n, (col_r <= LAST_COL) && (row_r <= LAST_ROW), "glyph walk counters out of range")

endmodule

`default_nettype wire

// ===== dv/tb_glyph_framebuffer_writer.sv =====
// Self-checking testbench for the glyph frame-buffer writer, with its own frame-store predictor.
module tb_glyph_framebuffer_writer
  import gfw_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Display geometry used for the instance and for the predictor alike.
  localparam int DISP_W = 128;
  localparam int DISP_H = 64;

  // Glyph cell size, in columns and rows.
  localparam int GLYPH_W = 5;
  localparam int GLYPH_H = 7;

  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1625;
  // After this many results the receiver stops taking results for a long stretch, so the
  // output register and the sequencer fill up and in_ready drops while the sender keeps offering.
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 600;
  // A clear is the longest command; this covers it with room to spare.
  localparam int DRAIN_CYCLES = 1200;
  // Worst case is every item a clear plus stalls, gaps and the clearing pass after reset.
  // The limit is several times that.
  localparam int TIMEOUT_NS   = 50_000_000;

  // Our own copy of the 5x7 font: five column bytes per code from 32 up, bit r is glyph row r.
  localparam logic [7:0] FONT_COLUMNS [475] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00, 8'h00,8'h07,8'h00,8'h07,8'h00,
    8'h14,8'h7F,8'h14,8'h7F,8'h14, 8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
    8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00, 8'h00,8'h1C,8'h22,8'h41,8'h00,
    8'h00,8'h41,8'h22,8'h1C,8'h00, 8'h14,8'h08,8'h3E,8'h08,8'h14, 8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08, 8'h00,8'h60,8'h60,8'h00,8'h00,
    8'h20,8'h10,8'h08,8'h04,8'h02, 8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31, 8'h18,8'h14,8'h12,8'h7F,8'h10,
    8'h27,8'h45,8'h45,8'h45,8'h39, 8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E, 8'h00,8'h36,8'h36,8'h00,8'h00,
    8'h00,8'h56,8'h36,8'h00,8'h00, 8'h08,8'h14,8'h22,8'h41,8'h00, 8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h51,8'h09,8'h06, 8'h32,8'h49,8'h79,8'h41,8'h3E,
    8'h7E,8'h11,8'h11,8'h11,8'h7E, 8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h09,8'h01,
    8'h3E,8'h41,8'h49,8'h49,8'h7A, 8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41, 8'h7F,8'h40,8'h40,8'h40,8'h40,
    8'h7F,8'h02,8'h04,8'h02,8'h7F, 8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h19,8'h29,8'h46,
    8'h46,8'h49,8'h49,8'h49,8'h31, 8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h3F,8'h40,8'h30,8'h40,8'h3F, 8'h63,8'h14,8'h08,8'h14,8'h63,
    8'h03,8'h04,8'h78,8'h04,8'h03, 8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h7F,8'h41,8'h41,8'h00,
    8'h02,8'h04,8'h08,8'h10,8'h20, 8'h00,8'h41,8'h41,8'h7F,8'h00, 8'h04,8'h02,8'h01,8'h02,8'h04,
    8'h40,8'h40,8'h40,8'h40,8'h40, 8'h00,8'h03,8'h05,8'h00,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
    8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20, 8'h38,8'h44,8'h44,8'h48,8'h7F,
    8'h38,8'h54,8'h54,8'h54,8'h18, 8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h08,8'h14,8'h54,8'h54,8'h3C,
    8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00, 8'h20,8'h40,8'h44,8'h3D,8'h00,
    8'h7F,8'h10,8'h28,8'h44,8'h00, 8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h78,8'h04,8'h78,
    8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38, 8'h7C,8'h14,8'h14,8'h14,8'h08,
    8'h08,8'h14,8'h14,8'h18,8'h7C, 8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
    8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C, 8'h1C,8'h20,8'h40,8'h20,8'h1C,
    8'h3C,8'h40,8'h30,8'h40,8'h3C, 8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C,
    8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00, 8'h00,8'h00,8'h7F,8'h00,8'h00,
    8'h00,8'h41,8'h36,8'h08,8'h00, 8'h10,8'h08,8'h08,8'h10,8'h08
  };

  // One row of the directed script. Where has_want is set, want is the result typed in by
  // hand; otherwise the predictor supplies the expected byte.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic       lit;
    logic [7:0] code;
    logic [9:0] idx;
    logic       has_want;
    logic [7:0] want;
  } script_row_t;

  localparam int SCRIPT_LEN = 27;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // The store is all zero after reset, at both ends of the index range.
    '{CMD_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd0,    1'b1, 8'h00},
    '{CMD_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd1023, 1'b1, 8'h00},
    // Corner pixels land in the first and the last byte of the store.
    '{CMD_PIXEL, 8'd0,   8'd0,   1'b1, 8'd0,   10'd0,    1'b1, 8'h00},
    '{CMD_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd0,    1'b1, 8'h01},
    '{CMD_PIXEL, 8'd127, 8'd63,  1'b1, 8'd0,   10'd0,    1'b1, 8'h00},
    '{CMD_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd1023, 1'b1, 8'h80},
    // Pixels just off the right and bottom edges, and at the far corner, are dropped.
    '{CMD_PIXEL, 8'd128, 8'd0,   1'b1, 8'd0,   10'd0,    1'b1, 8'h00},
    '{CMD_PIXEL, 8'd0,   8'd64,  1'b1, 8'd0,   10'd0,    1'b1, 8'h00},
    '{CMD_PIXEL, 8'd255, 8'd255, 1'b1, 8'd0,   10'd0,    1'b1, 8'h00},
    '{CMD_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd128,  1'b1, 8'h00},
    // Clearing a pixel takes its bit back out.
    '{CMD_PIXEL, 8'd0,   8'd0,   1'b0, 8'd0,   10'd0,    1'b1, 8'h00},
    '{CMD_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd0,    1'b1, 8'h00},
    // Capital A at the origin: its column bytes appear as stored bytes.
    '{CMD_CHAR,  8'd0,   8'd0,   1'b0, 8'd65,  10'd0,    1'b1, 8'h00},
    '{CMD_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd0,    1'b1, 8'h7E},
    '{CMD_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd2,    1'b1, 8'h11},
    // Codes outside the printable range draw nothing.
    '{CMD_CHAR,  8'd10,  8'd0,   1'b0, 8'd31,  10'd0,    1'b1, 8'h00},
    '{CMD_CHAR,  8'd10,  8'd0,   1'b0, 8'd127, 10'd0,    1'b1, 8'h00},
    '{CMD_CHAR,  8'd10,  8'd0,   1'b0, 8'd255, 10'd0,    1'b1, 8'h00},
    '{CMD_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd10,   1'b1, 8'h00},
    // The underscore sits on the glyph's bottom row.
    '{CMD_CHAR,  8'd20,  8'd0,   1'b0, 8'd95,  10'd0,    1'b1, 8'h00},
    '{CMD_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd20,   1'b1, 8'h40},
    // The last code clipped at the bottom right, then a space that wraps around both axes
    // and blanks part of the A. The reads that follow come from the predictor.
    '{CMD_CHAR,  8'd124, 8'd58,  1'b0, 8'd126, 10'd0,    1'b1, 8'h00},
    '{CMD_CHAR,  8'd254, 8'd254, 1'b0, 8'd32,  10'd0,    1'b1, 8'h00},
    '{CMD_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd1021, 1'b0, 8'h00},
    '{CMD_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd0,    1'b0, 8'h00},
    // Clear wipes the whole store.
    '{CMD_CLEAR, 8'd0,   8'd0,   1'b0, 8'd0,   10'd0,    1'b1, 8'h00},
    '{CMD_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd1023, 1'b1, 8'h00}
  };

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [1:0] in_cmd        = CMD_READ;
  logic [7:0] in_x_pos      = '0;
  logic [7:0] in_y_pos      = '0;
  logic       in_pixel_on   = 1'b0;
  logic [7:0] in_char_code  = '0;
  logic [9:0] in_read_index = '0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [7:0] out_read_data;

  // Hand-typed expectation that travels with the transaction on offer.
  logic       offer_has_want = 1'b0;
  logic [7:0] offer_want     = '0;

  // Predictor state and the bytes still owed by the block, oldest first.
  logic [7:0] shadow_fb [STORE_DEPTH];
  logic [7:0] owed_read_data [$];
  logic [7:0] predicted_byte;
  logic [7:0] owed_byte;
  int         mismatch_count = 0;

  // Receiver state: results taken so far and the stall still to serve.
  int         results_taken;
  int         stall_left;
  int         next_stall;

  glyph_framebuffer_writer #(
    .DISP_WIDTH (DISP_W),
    .DISP_HEIGHT(DISP_H)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_x_pos     (in_x_pos),
    .in_y_pos     (in_y_pos),
    .in_pixel_on  (in_pixel_on),
    .in_char_code (in_char_code),
    .in_read_index(in_read_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_read_data(out_read_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor. Each pixel is one bit of a page byte: page y/8, column x, bit y%8.
  // ---------------------------------------------------------------------------------------
  function automatic void wipe_shadow();
    int i;
    for (i = 0; i < STORE_DEPTH; i++) shadow_fb[i] = 8'h00;
  endfunction

  // Pixels off the display, or whose byte would fall past the end of the store, are dropped.
  function automatic void plot_pixel(input logic [7:0] px, input logic [7:0] py,
                                     input logic lit);
    int store_pos;
    if (int'(px) >= DISP_W || int'(py) >= DISP_H) return;
    store_pos = int'(py >> 3) * DISP_W + int'(px);
    if (store_pos >= STORE_DEPTH) return;
    shadow_fb[store_pos][py[2:0]] = lit;
  endfunction

  // All 35 cells of the glyph are written, so clear bits erase what was under them. Cell
  // coordinates wrap at 256 before the bounds check, which the 8-bit sums do for us.
  function automatic void draw_glyph(input logic [7:0] gx, input logic [7:0] gy,
                                     input logic [7:0] code);
    int         base;
    int         c;
    int         r;
    logic [7:0] column;
    logic [7:0] cx;
    logic [7:0] ry;
    if (code < FIRST_CODE || code > LAST_CODE) return;
    base = (int'(code) - int'(FIRST_CODE)) * GLYPH_W;
    for (c = 0; c < GLYPH_W; c++) begin
      column = FONT_COLUMNS[base + c];
      cx = gx + 8'(c);
      for (r = 0; r < GLYPH_H; r++) begin
        ry = gy + 8'(r);
        plot_pixel(cx, ry, column[r]);
      end
    end
  endfunction

  // Applies one command to the shadow store and returns the byte the block should report.
  function automatic logic [7:0] run_command(input cmd_t cmd, input logic [7:0] x,
                                             input logic [7:0] y, input logic lit,
                                             input logic [7:0] code, input logic [9:0] idx);
    case (cmd)
      CMD_CLEAR: wipe_shadow();
      CMD_PIXEL: plot_pixel(x, y, lit);
      CMD_CHAR:  draw_glyph(x, y, code);
      default:   return shadow_fb[idx];
    endcase
    return 8'h00;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Scoreboard. Every accepted input transaction owes exactly one result byte; results are
  // matched in order against those debts.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      wipe_shadow();
    end else begin
      if (in_valid && in_ready) begin
        // The predictor always runs so the shadow store stays in step, even when the byte
        // to compare against was typed in by hand.
        predicted_byte = run_command(cmd_t'(in_cmd), in_x_pos, in_y_pos, in_pixel_on,
                                     in_char_code, in_read_index);
        owed_read_data.push_back(offer_has_want ? offer_want : predicted_byte);
      end
      if (out_valid && out_ready) begin
        if (owed_read_data.size() == 0) begin
          $display("%0t: read_data expected none, actual %02h", $time, out_read_data);
          mismatch_count++;
        end else begin
          owed_byte = owed_read_data.pop_front();
          if (out_read_data !== owed_byte) begin
            $display("%0t: read_data expected %02h, actual %02h", $time, owed_byte,
                     out_read_data);
            mismatch_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver. After each result it draws a random stall that it serves once the
  // next result is on offer, so stalls meet results of every kind. Some stretches run with
  // no stalls at all, and once it holds off for a long time to back the block up.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready     <= 1'b0;
      stall_left    <= 0;
      results_taken <= 0;
    end else if (out_valid && out_ready) begin
      next_stall = ((results_taken / 50) % 3 == 0) ? 0 : $urandom_range(0, 4);
      if (results_taken == HOLD_AT) next_stall = HOLD_CYCLES;
      results_taken <= results_taken + 1;
      stall_left    <= next_stall;
      out_ready     <= (next_stall == 0);
    end else if (stall_left > 0) begin
      if (out_valid) begin
        stall_left <= stall_left - 1;
        out_ready  <= (stall_left == 1);
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sender. Offers one transaction after an optional gap and returns at the edge where it
  // is accepted. With no gap, valid simply stays high and only the payload moves on.
  // ---------------------------------------------------------------------------------------
  task automatic offer_command(input cmd_t cmd, input logic [7:0] x, input logic [7:0] y,
                               input logic lit, input logic [7:0] code,
                               input logic [9:0] idx, input logic has_want,
                               input logic [7:0] want, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_x_pos       <= x;
    in_y_pos       <= y;
    in_pixel_on    <= lit;
    in_char_code   <= code;
    in_read_index  <= idx;
    offer_has_want <= has_want;
    offer_want     <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    int         n;
    int         pick;
    int         gap;
    cmd_t       cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] code;
    logic       lit;
    logic [9:0] idx;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The block clears its store after reset with in_ready low; the first handshake
    // simply waits that out.
    for (n = 0; n < SCRIPT_LEN; n++) begin
      offer_command(SCRIPT[n].cmd, SCRIPT[n].x, SCRIPT[n].y, SCRIPT[n].lit, SCRIPT[n].code,
                    SCRIPT[n].idx, SCRIPT[n].has_want, SCRIPT[n].want,
                    $urandom_range(0, 4));
    end

    // Random part: mostly pixels, glyphs and reads that land on the screen, with full-range
    // coordinates and codes mixed in for clipping, wrapping and unprintable codes. Clears
    // are rare so that the store builds up content for the reads to find.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        cmd = CMD_CLEAR;
      end else if (pick < 31) begin
        cmd = CMD_PIXEL;
      end else if (pick < 66) begin
        cmd = CMD_CHAR;
      end else begin
        cmd = CMD_READ;
      end
      x = 8'($urandom_range(0, 255));
      y = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) begin
        x = 8'($urandom_range(0, DISP_W - 1));
        y = 8'($urandom_range(0, DISP_H - 1));
      end
      if ($urandom_range(0, 15) == 0) x = 8'($urandom_range(250, 255));
      if ($urandom_range(0, 15) == 0) y = 8'($urandom_range(249, 255));
      code = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 4) != 0) code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
      lit = 1'($urandom_range(0, 1));
      idx = 10'($urandom_range(0, STORE_DEPTH - 1));
      gap = ((n / 64) % 4 == 0) ? 0 : $urandom_range(0, 4);
      offer_command(cmd, x, y, lit, code, idx, 1'b0, 8'h00, gap);
    end
    in_valid <= 1'b0;

    while (owed_read_data.size() != 0) @(posedge clk);
    // Let any stray extra result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("glyph_framebuffer_writer regression: pass");
    end else begin
      $display("glyph_framebuffer_writer regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("glyph_framebuffer_writer regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gfw_pkg.sv
rtl/gfw_ram.sv
rtl/gfw_pix_unit.sv
rtl/glyph_framebuffer_writer.sv
dv/tb_glyph_framebuffer_writer.sv
